// File: rtl/ehte_pkg.sv
// shared types, constants and helpers for the expiring hash table engine
// no dependencies; imported by every module of the block
package ehte_pkg;

  localparam int unsigned DEPTH_DEF       = 1024;
  localparam int unsigned KEY_BYTES_DEF   = 8;
  localparam int unsigned VALUE_BYTES_DEF = 8;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned EXP_W    = 33;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOTS_W  = 11;
  localparam int unsigned MAXREC_W = 5;
  localparam int unsigned CFG_W    = 11;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  localparam logic CFG_ACTIVE_SLOTS = 1'b0;
  localparam logic CFG_MAX_RECORD   = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 3'd4;

  typedef struct packed {
    logic [HASH_W-1:0]       hash;
    logic signed [EXP_W-1:0] expiry;
  } slot_data_t;

  // keeps the low len bytes of a 64-bit word
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      if (i < int'(len)) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// File: rtl/ehte_mod.sv
// iterative remainder unit, one quotient bit per cycle
// depends on ehte_pkg
module ehte_mod
  import ehte_pkg::*;
#(
  parameter int unsigned NW = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [NW-1:0]     divisor,
  output logic              done,
  output logic [NW-1:0]     rem
);

  localparam int unsigned CW = $clog2(HASH_W + 1);

  logic [CW-1:0]     cnt_r;
  logic [HASH_W-1:0] q_r;
  logic [NW-1:0]     rem_r;
  logic              done_r;
  logic [NW:0]       trial;
  logic [NW:0]       rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[HASH_W-1]};
    rem_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(HASH_W);
        rem_r <= '0;
        q_r   <= dividend;
      end else if (cnt_r != '0) begin
        rem_r <= rem_nxt[NW-1:0];
        q_r   <= {q_r[HASH_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/ehte_slot_ram.sv
// slot memory: hash and expiry per slot, cleared by a sweep after reset
// depends on ehte_pkg
module ehte_slot_ram
  import ehte_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [AW-1:0] rd_addr,
  output slot_data_t rd_data,
  input  logic       we,
  input  logic [AW-1:0] wr_addr,
  input  slot_data_t wr_data,
  output logic       clr_busy
);

  slot_data_t    mem [DEPTH];
  slot_data_t    rd_data_r;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// File: rtl/ehte_rec_ram.sv
// record memory: key, key length, value and value length per slot
// depends on ehte_pkg
module ehte_rec_ram
  import ehte_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned KW    = 64,
  parameter int unsigned VW    = 64
) (
  input  logic             clk,
  input  logic [AW-1:0]    rd_addr,
  output logic [KW-1:0]    rd_key,
  output logic [LEN_W-1:0] rd_klen,
  output logic [VW-1:0]    rd_val,
  output logic [LEN_W-1:0] rd_vlen,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [KW-1:0]    wr_key,
  input  logic [LEN_W-1:0] wr_klen,
  input  logic [VW-1:0]    wr_val,
  input  logic [LEN_W-1:0] wr_vlen
);

  localparam int unsigned RW = KW + VW + 2 * LEN_W;

  logic [RW-1:0] mem [DEPTH];
  logic [RW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= {wr_key, wr_klen, wr_val, wr_vlen};
    rd_r <= mem[rd_addr];
  end

  assign {rd_key, rd_klen, rd_val, rd_vlen} = rd_r;

endmodule

// File: rtl/expiring_hash_table_engine_core.sv
// Expiring hash table engine. A request (put or get with key, hash, value,
// expiry and time) enters on the in_ channel and gives exactly one result
// (status, value, value length) on the out_ channel; both use valid/stall.
// The table start slot is hash mod active_slots, found by a bit-serial
// remainder unit. A probe reads the slot and record memories (registered
// reads) in S_RD and checks the slot in S_EV. Writes are done in S_WR and,
// when an update moves the record to an expired slot, in S_WR2; the result
// is registered in S_FIN. A record that is too large skips the remainder
// and probe steps. One request is worked on at a time; the next one is
// accepted as soon as the engine is free, even while a result waits.
// After reset a clearing sweep zeroes every slot, one per cycle; no request
// is taken meanwhile, configuration writes are. A stalled result is held in
// the output register unchanged. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// depends on ehte_pkg, ehte_mod, ehte_slot_ram, ehte_rec_ram
module expiring_hash_table_engine_core
  import ehte_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEF,
  parameter int unsigned KEY_BYTES   = KEY_BYTES_DEF,
  parameter int unsigned VALUE_BYTES = VALUE_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [HASH_W-1:0]       in_key_hash,
  input  logic [DATA_W-1:0]       in_key_bytes,
  input  logic [LEN_W-1:0]        in_key_len,
  input  logic [DATA_W-1:0]       in_value_in,
  input  logic [LEN_W-1:0]        in_value_len,
  input  logic signed [EXP_W-1:0] in_expiry_in,
  input  logic [HASH_W-1:0]       in_now_time,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic [DATA_W-1:0]       out_value,
  output logic [LEN_W-1:0]        out_value_len
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = 8 * KEY_BYTES;
  localparam int unsigned VW = 8 * VALUE_BYTES;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_RD, S_EV, S_WR, S_WR2, S_FIN
  } state_t;

  state_t state_r;

  logic [SLOTS_W-1:0]  active_slots_r;
  logic [MAXREC_W-1:0] max_rec_r;

  logic                    op_r;
  logic [HASH_W-1:0]       h_r;
  logic [KW-1:0]           key_r;
  logic [LEN_W-1:0]        klen_r;
  logic [VW-1:0]           val_r;
  logic [LEN_W-1:0]        vlen_r;
  logic signed [EXP_W-1:0] exp_r;
  logic signed [EXP_W:0]   now_r;
  logic [NW-1:0]           n_r;
  logic [AW-1:0]           first_r, cur_r, e_s_r, l_s_r, nd_s_r;
  logic                    has_exp_r, has_lru_r, needle_r, empty_r;
  logic signed [EXP_W-1:0] lru_exp_r;
  logic [STATUS_W-1:0]     status_r;
  logic [VW-1:0]           fval_r;
  logic [LEN_W-1:0]        fvlen_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]   out_value_r;
  logic [LEN_W-1:0]    out_vlen_r;

  logic          mod_start, mod_done, clr_busy;
  logic          mod_busy_r;
  logic [NW-1:0] mod_rem;

  // request checks and derived values
  logic [HASH_W-1:0]   h_in;
  logic [MAXREC_W-1:0] rec_len;
  logic                too_large;
  logic [31:0]         n_wide;
  logic                accept;

  always_comb begin
    h_in    = (in_key_hash == '0) ? HASH_W'(1) : in_key_hash;
    rec_len = MAXREC_W'(in_key_len) + MAXREC_W'(in_value_len);
    too_large = (32'(in_key_len) > KEY_BYTES) ||
                (in_opcode == OP_PUT && 32'(in_value_len) > VALUE_BYTES) ||
                (in_opcode == OP_PUT && rec_len > max_rec_r) ||
                (in_opcode == OP_GET && MAXREC_W'(in_key_len) > max_rec_r);
    if (active_slots_r == '0) n_wide = 32'd1;
    else if (32'(active_slots_r) > TABLE_DEPTH) n_wide = 32'(TABLE_DEPTH);
    else n_wide = 32'(active_slots_r);
  end

  assign in_stall = (state_r != S_IDLE) || clr_busy;
  assign accept   = in_valid && !in_stall;

  // remainder unit
  assign mod_start = (state_r == S_DIV) && !mod_busy_r;

  ehte_mod #(.NW(NW)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(h_r),
    .divisor (n_r),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // memories
  slot_data_t       slot_rd, slot_wdata;
  logic             slot_we, rec_we;
  logic [AW-1:0]    slot_waddr, rec_waddr;
  logic [KW-1:0]    rec_key;
  logic [LEN_W-1:0] rec_klen, rec_vlen;
  logic [VW-1:0]    rec_val;

  ehte_slot_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_slot (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (cur_r),
    .rd_data (slot_rd),
    .we      (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .clr_busy(clr_busy)
  );

  ehte_rec_ram #(.DEPTH(TABLE_DEPTH), .AW(AW), .KW(KW), .VW(VW)) u_rec (
    .clk    (clk),
    .rd_addr(cur_r),
    .rd_key (rec_key),
    .rd_klen(rec_klen),
    .rd_val (rec_val),
    .rd_vlen(rec_vlen),
    .we     (rec_we),
    .wr_addr(rec_waddr),
    .wr_key (key_r),
    .wr_klen(klen_r),
    .wr_val (val_r),
    .wr_vlen(vlen_r)
  );

  // probe evaluation
  logic          ev_match, ev_empty, ev_expired, ev_lru, ev_circle;
  logic [NW-1:0] cur_inc;
  logic [AW-1:0] cur_next;

  always_comb begin
    ev_match   = (slot_rd.hash == h_r) && (rec_klen == klen_r) && (rec_key == key_r);
    ev_empty   = (slot_rd.hash == '0) && (slot_rd.expiry == '0);
    ev_expired = $signed({slot_rd.expiry[EXP_W-1], slot_rd.expiry}) < now_r;
    ev_lru     = !has_lru_r || (slot_rd.expiry < lru_exp_r);
    cur_inc    = NW'(cur_r) + NW'(1);
    cur_next   = (cur_inc >= n_r) ? '0 : cur_inc[AW-1:0];
    ev_circle  = (cur_next == first_r);
  end

  // write-back
  logic [AW-1:0] ins_addr;

  always_comb begin
    if (has_exp_r) ins_addr = e_s_r;
    else if (empty_r) ins_addr = cur_r;
    else ins_addr = l_s_r;
    slot_we    = 1'b0;
    rec_we     = 1'b0;
    slot_waddr = nd_s_r;
    rec_waddr  = nd_s_r;
    slot_wdata.hash   = h_r;
    slot_wdata.expiry = exp_r;
    if (state_r == S_WR) begin
      if (op_r == OP_GET) begin
        // negative expiry keeps the stored one
        slot_we = needle_r && !exp_r[EXP_W-1];
      end else if (!needle_r) begin
        slot_we    = 1'b1;
        rec_we     = 1'b1;
        slot_waddr = ins_addr;
        rec_waddr  = ins_addr;
      end else if (has_exp_r) begin
        slot_we           = 1'b1;
        slot_wdata.expiry = '0;
      end else begin
        slot_we = 1'b1;
        rec_we  = 1'b1;
      end
    end else if (state_r == S_WR2) begin
      slot_we    = 1'b1;
      rec_we     = 1'b1;
      slot_waddr = e_s_r;
      rec_waddr  = e_s_r;
    end
  end

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      active_slots_r <= SLOTS_W'(1024);
      max_rec_r      <= MAXREC_W'(16);
      out_valid_r    <= 1'b0;
      mod_busy_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACTIVE_SLOTS: active_slots_r <= cfg_data[SLOTS_W-1:0];
          CFG_MAX_RECORD:   max_rec_r      <= cfg_data[MAXREC_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_FIN && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r      <= in_opcode;
            h_r       <= h_in;
            key_r     <= KW'(in_key_bytes & byte_mask(in_key_len));
            klen_r    <= in_key_len;
            val_r     <= VW'(in_value_in & byte_mask(in_value_len));
            vlen_r    <= in_value_len;
            exp_r     <= in_expiry_in;
            now_r     <= (in_opcode == OP_GET) ? '0 : $signed({2'b00, in_now_time});
            n_r       <= n_wide[NW-1:0];
            has_exp_r <= 1'b0;
            has_lru_r <= 1'b0;
            needle_r  <= 1'b0;
            empty_r   <= 1'b0;
            fval_r    <= '0;
            fvlen_r   <= '0;
            if (too_large) begin
              status_r <= STAT_TOO_LARGE;
              state_r  <= S_FIN;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          mod_busy_r <= !mod_done;
          if (mod_done) begin
            first_r <= mod_rem[AW-1:0];
            cur_r   <= mod_rem[AW-1:0];
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_EV;
        S_EV: begin
          if (ev_match) begin
            needle_r <= 1'b1;
            nd_s_r   <= cur_r;
            fval_r   <= rec_val;
            fvlen_r  <= rec_vlen;
            state_r  <= S_WR;
          end else if (ev_empty) begin
            empty_r <= 1'b1;
            state_r <= S_WR;
          end else begin
            if (!has_exp_r && ev_expired) begin
              has_exp_r <= 1'b1;
              e_s_r     <= cur_r;
            end
            if (ev_lru) begin
              has_lru_r <= 1'b1;
              l_s_r     <= cur_r;
              lru_exp_r <= slot_rd.expiry;
            end
            cur_r   <= cur_next;
            state_r <= ev_circle ? S_WR : S_RD;
          end
        end
        S_WR: begin
          if (op_r == OP_GET) begin
            status_r <= needle_r ? STAT_FOUND : STAT_NOT_FOUND;
            state_r  <= S_FIN;
          end else if (!needle_r) begin
            status_r <= STAT_INSERTED;
            state_r  <= S_FIN;
          end else begin
            status_r <= STAT_UPDATED;
            state_r  <= has_exp_r ? S_WR2 : S_FIN;
          end
        end
        S_WR2: state_r <= S_FIN;
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_status_r <= status_r;
            out_value_r  <= (status_r == STAT_FOUND) ? DATA_W'(fval_r) : '0;
            out_vlen_r   <= (status_r == STAT_FOUND) ? fvlen_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value     = out_value_r;
  assign out_value_len = out_vlen_r;

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE || clr_busy) |-> in_stall)
    else $error("request taken while engine busy");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV) |-> (NW'(cur_r) < n_r))
    else $error("probe slot outside active range");

  a_value_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_FOUND) |-> (out_value_r == '0 && out_vlen_r == '0))
    else $error("value returned without a hit");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_EV) |-> (!slot_we && !rec_we))
    else $error("memory write outside write-back");

endmodule
